// File: src/softmax_cross_entropy_loss_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the loss block
// Same-cycle and next-cycle implication checks, reset disabled.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH
`define SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH

// check cons in the same cycle as ante
`define SCE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// check cons in the cycle after ante
`define SCE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg
// Types, constants and coefficient tables for the loss block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sce_pkg;

   localparam int N_MAX     = 1024;
   localparam int CNT_W     = $clog2(N_MAX + 1);
   localparam int ADDR_W    = $clog2(N_MAX);
   localparam int EXP_W     = CNT_W + 16;
   localparam int LOGIT_W   = 24;
   localparam int LABEL_W   = 17;
   localparam int LOSS_W    = 40;
   localparam int PCNT_W    = 11;
   localparam int LN_W      = 24;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = 2;

   localparam logic [16:0] LOG2E_Q16     = 17'd94548;
   localparam logic [17:0] LN2_Q16       = 18'd45426;
   localparam logic [LN_W-1:0] LOG_EMPTY = LN_W'(-5767168);
   localparam logic [LOGIT_W-1:0] MIN_LOGIT = {1'b1, {(LOGIT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit;
      logic [LABEL_W-1:0]        label;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [LOSS_W-1:0] loss;
      logic [PCNT_W-1:0]        pair_count;
      logic                     overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit;
      logic [LABEL_W-1:0]        label;
      logic                      last;
      logic                      keep;
   } entry_type;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit;
      logic [LABEL_W-1:0]        label;
   } word_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_EXP, ST_NORM, ST_DIV, ST_POLY, ST_LN, ST_LOSS, ST_EMIT
   } state_type;

   function automatic logic [17:0] exp_coef(input logic [1:0] k);
      logic [17:0] c;
      unique case (k)
         2'd0:    c = 18'd3638;
         2'd1:    c = 18'd15744;
         2'd2:    c = 18'd45426;
         default: c = 18'd65536;
      endcase
      return c;
   endfunction

   function automatic logic [17:0] log_coef(input logic [2:0] k);
      logic [17:0] c;
      unique case (k)
         3'd0:    c = 18'd7282;
         3'd1:    c = 18'd9362;
         3'd2:    c = 18'd13107;
         3'd3:    c = 18'd21845;
         default: c = 18'd65536;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: src/sce_front.sv
// ----------------------------------------------------------------------------
// sce_front
// Accepts items and marks each one as stored or dropped by capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sce_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  sce_pkg::req_type      req_data,
   output logic                  push,
   input  wire logic             q_ready,
   output sce_pkg::entry_type    push_entry
);
   import sce_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             keep;

   assign keep      = cnt_ff < CNT_W'(N_MAX);
   assign req_ready = q_ready;
   assign push      = req_valid && q_ready;

   always_comb begin
      push_entry.logit = req_data.logit;
      push_entry.label = req_data.label;
      push_entry.last  = req_data.last;
      push_entry.keep  = keep;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push) begin
         if (req_data.last) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: src/sce_queue.sv
// ----------------------------------------------------------------------------
// sce_queue
// Short queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sce_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  sce_pkg::entry_type    push_entry,
   output logic                  q_ready,
   output logic                  q_valid,
   input  wire logic             pop,
   output sce_pkg::entry_type    q_entry
);
   import sce_pkg::*;

   entry_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ff, rd_ff;
   logic [Q_PTR_W:0]    fill_ff;

   assign q_ready = fill_ff != (Q_PTR_W+1)'(Q_DEPTH);
   assign q_valid = fill_ff != '0;
   assign q_entry = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// File: src/sce_back.sv
// ----------------------------------------------------------------------------
// sce_back
// Stores pairs, runs the exp pass, the log unit and the loss pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sce_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  pop,
   input  sce_pkg::entry_type    q_entry,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sce_pkg::rsp_type      rsp_data
);
   import sce_pkg::*;
   `include "softmax_cross_entropy_loss_assert.svh"

   word_type mem [N_MAX];
   word_type rd_ff;

   state_type state_ff, state_in;
   logic [4:0]                step_ff;
   logic [CNT_W-1:0]          cnt_ff, idx_ff;
   logic signed [LOGIT_W-1:0] max_ff;
   logic                      drop_ff;
   logic [EXP_W-1:0]          sum_ff;
   logic signed [LOSS_W:0]    acc_ff;
   logic [40:0]               prod_ff;
   logic [24:0]               t_ff;
   logic [17:0]               p_ff;
   logic [EXP_W-1:0]          m_ff;
   logic signed [5:0]         e_ff;
   logic [18:0]               rem_ff, div_ff;
   logic [15:0]               z_ff, z2_ff;
   logic [17:0]               lnm_ff;
   logic signed [LN_W-1:0]    ln_ff;
   logic signed [25:0]        ls_ff;
   logic [LABEL_W-1:0]        lab_ff;
   logic signed [43:0]        lp_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic elem_last, norm_ok, out_free, load_out;
   logic [24:0] mag;
   logic [8:0]  n_exp;
   logic [15:0] f_exp;
   logic [16:0] g_exp;
   logic [34:0] hp;
   logic [EXP_W-1:0] term;
   logic [18:0] rem2;
   logic [33:0] pp;
   logic signed [43:0] lp_mag;
   logic [27:0] rnd;
   logic signed [LOSS_W+1:0] neg;
   logic signed [23:0] e_ln;

   assign elem_last = (idx_ff + 1'b1) == cnt_ff;
   assign norm_ok   = (m_ff >> 17) == '0 && m_ff[16];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // exp datapath
   always_comb begin
      mag   = 25'(max_ff) - 25'(rd_ff.logit);
      n_exp = t_ff[24:16];
      f_exp = t_ff[15:0];
      g_exp = 17'h10000 - {1'b0, f_exp};
      hp    = 35'(p_ff) * 35'(g_exp);
      if (n_exp >= 9'd17) begin
         term = '0;
      end else if (f_exp == '0) begin
         term = EXP_W'(17'h10000 >> n_exp[4:0]);
      end else begin
         term = EXP_W'((19'(p_ff) + (19'd1 << n_exp[4:0])) >> (n_exp[4:0] + 5'd1));
      end
   end

   // log and loss datapath
   always_comb begin
      rem2   = {rem_ff[17:0], 1'b0};
      pp     = 34'(p_ff) * 34'(z2_ff);
      lp_mag = lp_ff[43] ? -lp_ff : lp_ff;
      rnd    = 28'((44'(lp_mag) + 44'd32768) >> 16);
      neg    = -(LOSS_W+2)'(acc_ff);
      e_ln   = 24'(e_ff) * 24'($signed({1'b0, LN2_Q16}));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: if (q_valid && q_entry.last) state_in = ST_EXP;
         ST_EXP:  if (step_ff == 5'd7 && elem_last) state_in = ST_NORM;
         ST_NORM: begin
            if (step_ff == '0 && sum_ff == '0) begin
               state_in = ST_LOSS;
            end else if (step_ff != '0 && norm_ok) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:  if (step_ff == 5'd15) state_in = ST_POLY;
         ST_POLY: if (step_ff == 5'd5) state_in = ST_LN;
         ST_LN:   if (step_ff == 5'd1) state_in = ST_LOSS;
         ST_LOSS: if (step_ff == 5'd3 && elem_last) state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_LOAD: pop = q_valid;
         ST_EMIT: load_out = out_free;
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff[ADDR_W-1:0]];
      if (pop && q_entry.keep) begin
         mem[cnt_ff[ADDR_W-1:0]] <= '{logit: q_entry.logit, label: q_entry.label};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         max_ff       <= MIN_LOGIT;
         drop_ff      <= 1'b0;
         sum_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff) begin
            step_ff <= '0;
         end else if ((state_ff == ST_EXP && step_ff == 5'd7) ||
                      (state_ff == ST_LOSS && step_ff == 5'd3) ||
                      state_ff == ST_LOAD || state_ff == ST_EMIT) begin
            step_ff <= '0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               idx_ff <= '0;
               if (pop) begin
                  if (q_entry.keep) begin
                     cnt_ff <= cnt_ff + 1'b1;
                     if (q_entry.logit > max_ff) max_ff <= q_entry.logit;
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  sum_ff <= '0;
               end
            end
            ST_EXP: begin
               if (step_ff == 5'd1) begin
                  prod_ff <= 41'(mag[23:0]) * 41'(LOG2E_Q16);
               end else if (step_ff == 5'd2) begin
                  t_ff <= 25'((prod_ff + 41'd32768) >> 16);
                  p_ff <= 18'd630;
               end else if (step_ff >= 5'd3 && step_ff <= 5'd6) begin
                  p_ff <= 18'(hp >> 16) + exp_coef(2'(step_ff - 5'd3));
               end else if (step_ff == 5'd7) begin
                  sum_ff <= sum_ff + term;
                  idx_ff <= elem_last ? '0 : idx_ff + 1'b1;
               end
            end
            ST_NORM: begin
               if (step_ff == '0) begin
                  m_ff <= sum_ff;
                  e_ff <= '0;
                  if (sum_ff == '0) ln_ff <= LOG_EMPTY;
               end else if ((m_ff >> 17) != '0) begin
                  m_ff <= m_ff >> 1;
                  e_ff <= e_ff + 6'sd1;
               end else if (!m_ff[16]) begin
                  m_ff <= m_ff << 1;
                  e_ff <= e_ff - 6'sd1;
               end else begin
                  rem_ff <= 19'(m_ff[15:0]);
                  div_ff <= 19'(m_ff[16:0]) + 19'h10000;
               end
               acc_ff <= '0;
            end
            ST_DIV: begin
               if (rem2 >= div_ff) begin
                  rem_ff <= rem2 - div_ff;
                  z_ff   <= {z_ff[14:0], 1'b1};
               end else begin
                  rem_ff <= rem2;
                  z_ff   <= {z_ff[14:0], 1'b0};
               end
            end
            ST_POLY: begin
               if (step_ff == '0) begin
                  z2_ff <= 16'((32'(z_ff) * 32'(z_ff)) >> 16);
                  p_ff  <= 18'd5958;
               end else begin
                  p_ff <= 18'(pp >> 16) + log_coef(3'(step_ff - 5'd1));
               end
            end
            ST_LN: begin
               if (step_ff == '0) begin
                  lnm_ff <= 18'(((35'(z_ff) * 35'(p_ff)) << 1) >> 16);
               end else begin
                  ln_ff <= LN_W'($signed({1'b0, lnm_ff})) + e_ln;
               end
            end
            ST_LOSS: begin
               if (step_ff == 5'd1) begin
                  ls_ff  <= 26'(rd_ff.logit) - 26'(max_ff) - 26'(ln_ff);
                  lab_ff <= rd_ff.label;
               end else if (step_ff == 5'd2) begin
                  lp_ff <= $signed({27'd0, lab_ff}) * 44'(ls_ff);
               end else if (step_ff == 5'd3) begin
                  if (lp_ff[43]) begin
                     acc_ff <= acc_ff - (LOSS_W+1)'(rnd);
                  end else begin
                     acc_ff <= acc_ff + (LOSS_W+1)'(rnd);
                  end
                  idx_ff <= elem_last ? '0 : idx_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (load_out) begin
                  if (neg > $signed((LOSS_W+2)'({1'b0, {(LOSS_W-1){1'b1}}}))) begin
                     rsp_ff.loss <= {1'b0, {(LOSS_W-1){1'b1}}};
                  end else if (neg < -$signed((LOSS_W+2)'({1'b1, {(LOSS_W-1){1'b0}}})))
                  begin
                     rsp_ff.loss <= {1'b1, {(LOSS_W-1){1'b0}}};
                  end else begin
                     rsp_ff.loss <= LOSS_W'(neg);
                  end
                  rsp_ff.pair_count <= PCNT_W'(cnt_ff);
                  rsp_ff.overflow   <= drop_ff;
                  cnt_ff  <= '0;
                  max_ff  <= MIN_LOGIT;
                  drop_ff <= 1'b0;
                  sum_ff  <= '0;
                  acc_ff  <= '0;
               end
            end
            default: idx_ff <= '0;
         endcase
      end
   end

   `SCE_ASSERT_IMPL(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CNT_W'(N_MAX))
   `SCE_ASSERT_IMPL(a_div_rem, clock, reset, state_ff == ST_DIV, rem_ff < div_ff)
   `SCE_ASSERT_NEXT(a_emit_clear, clock, reset, load_out, cnt_ff == '0 && rsp_valid_ff)

endmodule
`default_nettype wire

// File: src/softmax_cross_entropy_loss.sv
// ----------------------------------------------------------------------------
// softmax_cross_entropy_loss
// Softmax cross-entropy loss over a set of logit/label pairs.
//
//   channel  dir  payload   handshake
//   req_     in   req_type  req_valid / req_ready
//   rsp_     out  rsp_type  rsp_valid / rsp_ready
//
// Each item passes through the queue and is stored by the back end while it loads.
// On the last item the back end runs the exp pass over the stored pairs;
// unless the sum is zero it normalizes it and runs the divider and the log
// polynomial; then it runs the loss pass over the stored pairs and emits.
// Synchronous reset clears all control state; the pair memory needs no clear.
// The front keeps taking items into the queue while the queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module softmax_cross_entropy_loss (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  sce_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output sce_pkg::rsp_type  rsp_data
);
   import sce_pkg::*;

   logic      push, q_ready, q_valid, pop;
   entry_type push_entry, q_entry;

   sce_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .push, .q_ready, .push_entry
   );

   sce_queue u_queue (
      .clock, .reset, .push, .push_entry, .q_ready, .q_valid, .pop, .q_entry
   );

   sce_back u_back (
      .clock, .reset, .q_valid, .pop, .q_entry, .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule
`default_nettype wire
